// File: design/npc_pkg.sv
// Package for the nearest palette color block: field widths, item codes and
// the packed color and squared-difference types shared by all modules.
// Depends on nothing.
`default_nettype none

package npc_pkg;

	localparam int PALETTE_DEPTH_DEF = 16;
	localparam int COLOR_W           = 8;
	localparam int IDX_W             = 4;
	localparam int COUNT_W           = 5;
	localparam int SQ_W              = 2 * COLOR_W;
	// three squares of 255 sum to 195075, below 2**18
	localparam int DIST_W            = SQ_W + 2;
	// wide enough to hold any palette depth up to 256 and any count
	localparam int WIDE_W            = 9;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [SQ_W-1:0] red;
		logic [SQ_W-1:0] green;
		logic [SQ_W-1:0] blue;
	} sq_t;

endpackage

`default_nettype wire

// File: design/npc_if.sv
// Handshake channels of the nearest palette color block: the request channel
// (load or query items) and the result channel. Depends on npc_pkg.
`default_nettype none

interface npc_req_if import npc_pkg::*;;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [IDX_W-1:0]   entry_index;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;

	modport source (output valid, kind, entry_index, red, green, blue, input ready);
	modport sink   (input valid, kind, entry_index, red, green, blue, output ready);
endinterface

interface npc_rsp_if import npc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] best_index;
	logic             no_match;

	modport source (output valid, best_index, no_match, input ready);
	modport sink   (input valid, best_index, no_match, output ready);
endinterface

`default_nettype wire

// File: design/nearest_palette_color_top.sv
// Top level of the nearest palette color block: request sequencer, palette
// store, distance stage and best-match tracking. Depends on npc_pkg, npc_if,
// npc_palette_mem and npc_dist.
//
// Usage:
//   req carries one item per valid/ready handshake. A load item (kind = 0)
//   writes red/green/blue into palette slot entry_index and gives no result;
//   slots at or beyond PALETTE_DEPTH are dropped. A query item (kind = 1)
//   gives one item on rsp: the index of the nearest loaded entry among
//   slots 0 to palette_count-1 (squared RGB distance, lowest index on a tie),
//   or no_match = 1 with best_index = 0 when palette_count is zero.
//   cfg_we/cfg_wdata write palette_count; write it only while idle. Counts
//   above PALETTE_DEPTH match over the whole palette.
// Timing:
//   A query walks the palette store one entry per cycle through its single
//   read port, over the effective count of entries; each entry passes the
//   memory read and distance registers before the compare, and the result
//   then goes through the result register. An empty palette query skips the
//   scan. req is not ready while a query is in flight.
// Reset and stall:
//   arst_n clears the count, the sequencer and the result valid; the palette
//   store is not cleared and must be loaded before it is queried. A stalled
//   rsp holds its item; the finished result then waits in the sequencer, and
//   loads and a new query are taken as soon as the result register frees up.
`default_nettype none

module nearest_palette_color_top import npc_pkg::*; #(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	npc_req_if.sink            req,
	npc_rsp_if.source          rsp,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(PALETTE_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic [COUNT_W-1:0] count_q;
	rgb_t               color_q;
	logic [AW-1:0]      scan_addr_q;
	logic [AW-1:0]      last_addr_q;
	logic [AW-1:0]      best_q;
	logic [DIST_W-1:0]  bestd_q;
	logic               nomatch_q;

	logic               vld_s1, last_s1, vld_s2, last_s2;
	logic [AW-1:0]      idx_s1, idx_s2;

	logic               rsp_valid_q;
	logic [IDX_W-1:0]   rsp_idx_q;
	logic               rsp_nm_q;

	logic               accept, is_query, load_ok;
	logic [WIDE_W-1:0]  idx_w, cnt_w, eff_w, best_w;
	logic               rd_en, scan_last;
	logic [AW-1:0]      wr_addr;
	rgb_t               req_color, entry_s1;
	sq_t                sq_s2;
	logic [DIST_W-1:0]  dist_sum;
	logic               take, rsp_free;

	// request side
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid & req.ready;
	assign is_query  = (req.kind == KIND_QUERY);
	assign req_color = '{red: req.red, green: req.green, blue: req.blue};

	assign idx_w   = WIDE_W'(req.entry_index);
	assign load_ok = accept & ~is_query & (idx_w < DEPTH_W);
	assign wr_addr = idx_w[AW-1:0];

	// saturate the count to the palette depth
	assign cnt_w = WIDE_W'(count_q);
	assign eff_w = (cnt_w > DEPTH_W) ? DEPTH_W : cnt_w;

	assign rd_en     = (state_q == ST_SCAN);
	assign scan_last = (scan_addr_q == last_addr_q);

	// compare stage: strict less keeps the lowest index on a tie
	assign dist_sum = DIST_W'(sq_s2.red) + DIST_W'(sq_s2.green) + DIST_W'(sq_s2.blue);
	assign take     = vld_s2 & (dist_sum < bestd_q);

	assign rsp_free = ~rsp_valid_q | rsp.ready;
	assign best_w   = WIDE_W'(best_q);

	npc_palette_mem #(
		.DEPTH (PALETTE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (load_ok),
		.wr_addr (wr_addr),
		.wr_data (req_color),
		.rd_en   (rd_en),
		.rd_addr (scan_addr_q),
		.rd_data (entry_s1)
	);

	npc_dist u_dist (
		.clk   (clk),
		.pixel (color_q),
		.entry (entry_s1),
		.sq_s2 (sq_s2)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && is_query) begin
						state_q <= (eff_w == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (vld_s2 && last_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query context and scan address
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			color_q     <= req_color;
			last_addr_q <= AW'(eff_w - WIDE_W'(1));
			scan_addr_q <= '0;
		end else if (rd_en) begin
			scan_addr_q <= scan_addr_q + AW'(1);
		end
	end

	// pipeline control beside the memory read and distance stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= rd_en;
			last_s1 <= rd_en & scan_last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr_q;
		idx_s2 <= idx_s1;
	end

	// best match so far
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			best_q    <= '0;
			bestd_q   <= '1;
			nomatch_q <= (eff_w == '0);
		end else if (take) begin
			best_q  <= idx_s2;
			bestd_q <= dist_sum;
		end
	end

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_idx_q <= best_w[IDX_W-1:0];
			rsp_nm_q  <= nomatch_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.best_index = rsp_idx_q;
	assign rsp.no_match   = rsp_nm_q;

endmodule

`default_nettype wire

// File: design/npc_palette_mem.sv
// Palette store: one write port, one read port, read data registered.
// Depends on npc_pkg.
`default_nettype none

module npc_palette_mem import npc_pkg::*; #(
	parameter int DEPTH = PALETTE_DEPTH_DEF,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  rgb_t          wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output rgb_t          rd_data
);

	rgb_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: design/npc_dist.sv
// Distance stage: absolute differences per channel and their squares,
// registered. Depends on npc_pkg.
`default_nettype none

module npc_dist import npc_pkg::*; (
	input  logic clk,
	input  rgb_t pixel,
	input  rgb_t entry,
	output sq_t  sq_s2
);

	logic [COLOR_W-1:0] dr, dg, db;

	always_comb begin
		dr = (pixel.red   > entry.red)   ? pixel.red   - entry.red   : entry.red   - pixel.red;
		dg = (pixel.green > entry.green) ? pixel.green - entry.green : entry.green - pixel.green;
		db = (pixel.blue  > entry.blue)  ? pixel.blue  - entry.blue  : entry.blue  - pixel.blue;
	end

	always_ff @(posedge clk) begin
		sq_s2.red   <= SQ_W'(dr) * SQ_W'(dr);
		sq_s2.green <= SQ_W'(dg) * SQ_W'(dg);
		sq_s2.blue  <= SQ_W'(db) * SQ_W'(db);
	end

endmodule

`default_nettype wire

// File: design/npc_checker.sv
// Port-level checks for the nearest palette color block and the bind that
// attaches them to the top level. Depends on npc_pkg and the top level.
`default_nettype none

module npc_checker import npc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             req_kind,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [IDX_W-1:0] rsp_best_index,
	input logic             rsp_no_match
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_index)
			&& $stable(rsp_no_match))
		else $error("result item changed while stalled");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_no_match |-> rsp_best_index == '0)
		else $error("no-match result with nonzero index");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind == KIND_QUERY |=> !req_ready)
		else $error("request taken right after a query");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind == KIND_LOAD |=> !$rose(rsp_valid))
		else $error("load item produced a result");

	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without a query in flight");

endmodule

bind nearest_palette_color_top npc_checker u_npc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_kind       (req.kind),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_best_index (rsp.best_index),
	.rsp_no_match   (rsp.no_match)
);

`default_nettype wire
